### design/fixed_point_divide_64_macros.svh
// Assertion macros for the fixed-point divider.
`ifndef FIXED_POINT_DIVIDE_64_MACROS_SVH
`define FIXED_POINT_DIVIDE_64_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define FPD64_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fpd64 check failed");

// Next-cycle implication, disabled during reset
`define FPD64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fpd64 check failed");

`else

`define FPD64_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FPD64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/fpd64_pkg.sv
// Shared constants, types and helpers of the fixed-point divider.
`default_nettype none

package fpd64_pkg;

	// Operand width that takes part in the arithmetic (8..64)
	localparam int unsigned DATA_W   = 64;
	// Port width of each operand and of the quotient
	localparam int unsigned WORD_W   = 64;
	// Widened dividend and the number of restoring steps
	localparam int unsigned NUM_W    = 2 * WORD_W;
	localparam int unsigned NUM_ITER = NUM_W;
	// Fraction bit count register
	localparam int unsigned FRAC_W   = 6;
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32);

	typedef logic [WORD_W-1:0] word_t;

	// Payload of one divider iteration stage
	typedef struct packed {
		logic             neg;  // quotient is negated at the end
		logic             dbz;  // divisor was zero
		word_t            dsr;  // divisor magnitude
		word_t            rem;  // partial remainder, below dsr unless the divisor is zero
		logic [NUM_W-1:0] num;  // dividend bits out at top, quotient bits in at bottom
	} iter_t;

	// Result beat
	typedef struct packed {
		logic  dbz;
		word_t quo;
	} res_t;

	// Sign-extend from bit DATA_W-1 to the port width
	function automatic word_t sext_w(input word_t v);
		return word_t'($signed(v << (WORD_W - DATA_W)) >>> (WORD_W - DATA_W));
	endfunction

endpackage

`default_nettype wire

### design/fixed_point_divide_64.sv
// Top level of the pipelined signed 64-bit fixed-point divider.
`default_nettype none

// Signed fixed-point divide: quotient = (dividend << frac_bits) / divisor, truncated
// toward zero, low 64 bits kept (an overflowing quotient wraps, no flag). A zero
// divisor returns quotient 0 with div_by_zero set. One operand pair is accepted
// every cycle while the skid buffer is empty. Each beat passes operand preparation,
// 128 restoring-division stages (one 65-bit trial subtract each, one per bit of
// the 128-bit widened dividend), one sign fix-up stage and the output register.
// frac_bits resets to 32 and may only be written while the divider holds no
// items. A stalled output freezes the whole pipeline one beat after the output
// register fills, the extra beat landing in a skid buffer.

module fixed_point_divide_64 import fpd64_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input beats
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [127:0]      s_tdata,   // [63:0] dividend, [127:64] divisor
	// Result beats
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,   // [63:0] quotient
	output logic [0:0]             m_tuser,   // [0] div_by_zero
	// Fraction bit count register
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [FRAC_W-1:0] cfg_data
);

	`include "fixed_point_divide_64_macros.svh"

	logic [FRAC_W-1:0] frac_bits_q;
	logic              en;
	logic              skid_full;
	logic [NUM_ITER:0] pipe_vld;
	iter_t             pipe_data [NUM_ITER+1];
	logic              post_vld;
	res_t              post_data;
	res_t              out_data;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q <= FRAC_RESET;
		end else if (cfg_valid) begin
			frac_bits_q <= cfg_data;
		end
	end

	// Global pipeline advance
	assign en       = !skid_full;
	assign s_tready = en;

	fpd64_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_tvalid),
		.dividend  (s_tdata[WORD_W-1:0]),
		.divisor   (s_tdata[2*WORD_W-1:WORD_W]),
		.frac_bits (frac_bits_q),
		.out_vld   (pipe_vld[0]),
		.out_data  (pipe_data[0])
	);

	// Restoring division, one quotient bit per stage
	for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
		fpd64_iter u_iter (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (pipe_vld[i]),
			.in_data  (pipe_data[i]),
			.out_vld  (pipe_vld[i+1]),
			.out_data (pipe_data[i+1])
		);
	end

	fpd64_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (pipe_vld[NUM_ITER]),
		.in_data  (pipe_data[NUM_ITER]),
		.out_vld  (post_vld),
		.out_data (post_data)
	);

	fpd64_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (post_vld),
		.in_data  (post_data),
		.full     (skid_full),
		.out_vld  (m_tvalid),
		.out_data (out_data),
		.out_rdy  (m_tready)
	);

	assign m_tdata    = out_data.quo;
	assign m_tuser[0] = out_data.dbz;

	// A filled skid implies the output register holds a beat
	`FPD64_ASSERT_NOW(a_skid_behind_out, clk, arst_n, !s_tready, m_tvalid)
	// A zero-divisor beat carries a zero quotient
	`FPD64_ASSERT_NOW(a_dbz_zero_quo, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0)
	// A frozen pipeline keeps its valid bits in place
	`FPD64_ASSERT_NEXT(a_freeze_holds, clk, arst_n, !s_tready, $stable(pipe_vld))

endmodule

`default_nettype wire

### design/fpd64_prep.sv
// Operand preparation: sign split, magnitudes, and fraction shift into the wide dividend.
`default_nettype none

module fpd64_prep import fpd64_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire word_t             dividend,
	input  wire word_t             divisor,
	input  wire logic [FRAC_W-1:0] frac_bits,
	output logic                   out_vld,
	output iter_t                  out_data
);

	word_t a;
	word_t b;
	logic  vld_s1;
	word_t ma_s1;
	word_t mb_s1;
	logic  neg_s1;
	logic  dbz_s1;
	logic  vld_s2;
	iter_t data_s2;

	assign a = sext_w(dividend);
	assign b = sext_w(divisor);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[WORD_W-1] ? word_t'(-a) : a;
			mb_s1  <= b[WORD_W-1] ? word_t'(-b) : b;
			neg_s1 <= a[WORD_W-1] ^ b[WORD_W-1];
			dbz_s1 <= (b == '0);
		end
	end

	// Stage 2: widen and shift the dividend by the fraction bit count
	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.neg <= neg_s1;
			data_s2.dbz <= dbz_s1;
			data_s2.dsr <= mb_s1;
			data_s2.rem <= '0;
			data_s2.num <= {{(NUM_W - WORD_W){1'b0}}, ma_s1} << frac_bits;
		end
	end

	assign out_vld  = vld_s2;
	assign out_data = data_s2;

endmodule

`default_nettype wire

### design/fpd64_iter.sv
// One restoring division step: shift in one dividend bit, trial subtract, emit one quotient bit.
`default_nettype none

module fpd64_iter import fpd64_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_vld,
	input  wire iter_t in_data,
	output logic       out_vld,
	output iter_t      out_data
);

	logic [WORD_W:0] trial;
	logic [WORD_W:0] diff;
	logic            fits;
	logic            vld_s1;
	iter_t           data_s1;

	// Partial remainder stays below the divisor, so the difference fits in WORD_W bits
	assign trial = {in_data.rem, in_data.num[NUM_W-1]};
	assign diff  = trial - {1'b0, in_data.dsr};
	assign fits  = !diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.neg <= in_data.neg;
			data_s1.dbz <= in_data.dbz;
			data_s1.dsr <= in_data.dsr;
			data_s1.rem <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			data_s1.num <= {in_data.num[NUM_W-2:0], fits};
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

`default_nettype wire

### design/fpd64_post.sv
// Result fix-up: apply the sign, wrap to the data width, force zero on a zero divisor.
`default_nettype none

module fpd64_post import fpd64_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_vld,
	input  wire iter_t in_data,
	output logic       out_vld,
	output res_t       out_data
);

	word_t mag;
	word_t sgn;
	logic  vld_s1;
	res_t  res_s1;

	// Low quotient bits, negated when the operand signs differ
	assign mag = in_data.num[WORD_W-1:0];
	assign sgn = in_data.neg ? word_t'(-mag) : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.dbz <= in_data.dbz;
			res_s1.quo <= in_data.dbz ? '0 : sext_w(sgn);
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = res_s1;

endmodule

`default_nettype wire

### design/fpd64_skid.sv
// Output register with a one-beat skid buffer; a full skid freezes the pipeline.
`default_nettype none

module fpd64_skid import fpd64_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_vld,
	input  wire res_t in_data,
	output logic      full,
	output logic      out_vld,
	output res_t      out_data,
	input  wire logic out_rdy
);

	logic push;
	logic out_vld_q;
	res_t out_q;
	logic skid_vld_q;
	res_t skid_q;

	// Pipeline advances only while the skid is empty, so a push never meets a full skid
	assign push = in_vld && !skid_vld_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_rdy) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !out_rdy) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_rdy) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !out_rdy) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign full     = skid_vld_q;
	assign out_vld  = out_vld_q;
	assign out_data = out_q;

endmodule

`default_nettype wire
